// ----- src/cre_pkg.sv -----
`default_nettype none

package cre_pkg;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_RADIUS = 2'd1,
        STATUS_SAT       = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
    } in_word_t;

    typedef struct packed {
        logic [31:0] radius;
        status_t     status;
    } out_word_t;

    localparam int unsigned DIMENSION = 3;
    localparam int unsigned SQRT_CELLS = 32;
    localparam int unsigned COS_CELLS = 30;
    localparam int unsigned RAD_CELLS = 32;
    localparam int unsigned LATENCY = 4 + SQRT_CELLS + 1 + COS_CELLS + 2 + SQRT_CELLS
                                      + RAD_CELLS + 1;

endpackage

`default_nettype wire

// ----- src/cre_sqrt_cell.sv -----
`default_nettype none

module cre_sqrt_cell (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] rad_in,
    input  wire logic [33:0] rem_in,
    input  wire logic [31:0] root_in,
    output logic      [63:0] rad_out,
    output logic      [33:0] rem_out,
    output logic      [31:0] root_out
);

    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [63:0] rad_next;
    logic [33:0] rem_next;
    logic [31:0] root_next;
    logic [35:0] t;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    always_comb
    begin
        t         = {rem_in, rad_in[63:62]};
        trial     = {2'b00, root_in, 2'b01};
        diff      = t - trial;
        ge        = (t >= trial);
        rem_next  = ge ? diff[33:0] : t[33:0];
        root_next = {root_in[30:0], ge};
        rad_next  = {rad_in[61:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

`default_nettype wire

// ----- src/cre_div_cell.sv -----
`default_nettype none

module cre_div_cell #(
    parameter int unsigned REM_W = 64,
    parameter int unsigned QUO_W = 30
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [REM_W-1:0] rem_in,
    input  wire logic [REM_W-1:0] den_in,
    input  wire logic             nbit,
    input  wire logic [QUO_W-1:0] quo_in,
    output logic      [REM_W-1:0] rem_out,
    output logic      [REM_W-1:0] den_out,
    output logic      [QUO_W-1:0] quo_out
);

    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] den_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [REM_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_next;
    logic [REM_W-1:0] t;
    logic             ge;

    always_comb
    begin
        t        = {rem_in[REM_W-2:0], nbit};
        ge       = (t >= den_in);
        rem_next = ge ? (t - den_in) : t;
        quo_next = {quo_in[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= quo_next;
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule

`default_nettype wire

// ----- src/curvature_radius_estimate_core.sv -----
// throughput: one word per cycle, fully pipelined through rows of square root
// and restoring divider cells, one bit per cell
// the whole row advances together; it halts only while the output word is stalled
// reset: asynchronous active low, empties the pipeline and sets min_denominator to 1
`default_nettype none

module curvature_radius_estimate_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire cre_pkg::in_word_t  item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output cre_pkg::out_word_t      result,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_data
);

    import cre_pkg::*;

    logic                 adv;
    logic [LATENCY-1:0]   vld_reg;
    logic [LATENCY-1:0]   vld_next;
    logic [31:0]          min_den_reg;

    // difference and magnitudes
    logic signed [31:0] s_in [DIMENSION];
    logic signed [31:0] e_in [DIMENSION];
    logic signed [31:0] t_in [DIMENSION];
    logic signed [32:0] d_comb [DIMENSION];
    logic [32:0]        dm_reg [DIMENSION];
    logic [31:0]        tm_reg [DIMENSION];
    logic [DIMENSION-1:0] dneg_reg;
    logic [DIMENSION-1:0] tneg_reg;

    // block scaling
    logic [29:0]        a_reg [DIMENSION];
    logic [29:0]        b_reg [DIMENSION];
    logic [30:0]        f_reg [DIMENSION];
    logic [DIMENSION-1:0] sgn_reg;
    logic [1:0]         sl_reg;
    logic               dor32;
    logic               dor31;
    logic               dor30;
    logic               tor31;
    logic               tor30;
    logic [1:0]         sd;
    logic [1:0]         st;
    logic [1:0]         sl;

    // products
    logic [59:0]        pab_reg [DIMENSION];
    logic [59:0]        paa_reg [DIMENSION];
    logic [59:0]        pbb_reg [DIMENSION];
    logic [61:0]        pff_reg [DIMENSION];
    logic [DIMENSION-1:0] sgn2_reg;
    logic [1:0]         sl2_reg;

    // sums
    logic signed [62:0] term [DIMENSION];
    logic signed [62:0] dot_reg;
    logic [61:0]        ld2_reg;
    logic [61:0]        tl2_reg;
    logic [63:0]        lf2_reg;
    logic [1:0]         sl3_reg;

    // first square root row, three lanes
    logic [63:0]        sq1_rad  [3][SQRT_CELLS+1];
    logic [33:0]        sq1_rem  [3][SQRT_CELLS+1];
    logic [31:0]        sq1_root [3][SQRT_CELLS+1];
    logic [61:0]        sq1_q_reg  [SQRT_CELLS];
    logic [1:0]         sq1_sl_reg [SQRT_CELLS];
    logic [61:0]        q_abs;

    // cosine setup
    logic [61:0]        p_reg;
    logic [61:0]        q_reg;
    logic [33:0]        len_reg;

    // cosine divider row
    logic [63:0]        dc_rem [COS_CELLS+1];
    logic [63:0]        dc_den [COS_CELLS+1];
    logic [29:0]        dc_quo [COS_CELLS+1];
    logic               dc_big_reg [COS_CELLS];
    logic               dc_pz_reg  [COS_CELLS];
    logic [33:0]        dc_len_reg [COS_CELLS];

    // c squared
    logic [30:0]        csel;
    logic [60:0]        cc_reg;
    logic [33:0]        len4_reg;
    logic [60:0]        v_reg;
    logic [33:0]        len5_reg;

    // second square root row
    logic [63:0]        sq2_rad  [SQRT_CELLS+1];
    logic [33:0]        sq2_rem  [SQRT_CELLS+1];
    logic [31:0]        sq2_root [SQRT_CELLS+1];
    logic [33:0]        sq2_len_reg [SQRT_CELLS];

    // radius divider row
    logic [31:0]        den;
    logic               nofin;
    logic               ovf;
    logic [32:0]        dr_rem [RAD_CELLS+1];
    logic [32:0]        dr_den [RAD_CELLS+1];
    logic [31:0]        dr_quo [RAD_CELLS+1];
    logic [31:0]        dr_nlow [RAD_CELLS+1];
    logic [31:0]        dr_nlow_reg [RAD_CELLS];
    logic               dr_nofin_reg [RAD_CELLS];
    logic               dr_ovf_reg   [RAD_CELLS];

    out_word_t          result_reg;
    out_word_t          result_next;

    assign adv          = !(vld_reg[LATENCY-1] && result_stall);
    assign item_stall   = !adv;
    assign result_valid = vld_reg[LATENCY-1];
    assign result       = result_reg;
    assign vld_next     = {vld_reg[LATENCY-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            min_den_reg <= 32'd1;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= vld_next;
            end
            if (cfg_we)
            begin
                min_den_reg <= cfg_data;
            end
        end
    end

    // stage 1
    always_comb
    begin
        s_in[0] = item.start_x;
        s_in[1] = item.start_y;
        s_in[2] = item.start_z;
        e_in[0] = item.end_x;
        e_in[1] = item.end_y;
        e_in[2] = item.end_z;
        t_in[0] = item.tangent_x;
        t_in[1] = item.tangent_y;
        t_in[2] = item.tangent_z;
        for (int i = 0; i < DIMENSION; i++)
        begin
            d_comb[i] = {e_in[i][31], e_in[i]} - {s_in[i][31], s_in[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < DIMENSION; i++)
            begin
                dm_reg[i]   <= d_comb[i][32] ? 33'(-d_comb[i]) : 33'(d_comb[i]);
                tm_reg[i]   <= t_in[i][31] ? 32'(-t_in[i]) : 32'(t_in[i]);
                dneg_reg[i] <= d_comb[i][32];
                tneg_reg[i] <= t_in[i][31];
            end
        end
    end

    // stage 2
    always_comb
    begin
        dor32 = 1'b0;
        dor31 = 1'b0;
        dor30 = 1'b0;
        tor31 = 1'b0;
        tor30 = 1'b0;
        for (int i = 0; i < DIMENSION; i++)
        begin
            dor32 = dor32 | dm_reg[i][32];
            dor31 = dor31 | dm_reg[i][31];
            dor30 = dor30 | dm_reg[i][30];
            tor31 = tor31 | tm_reg[i][31];
            tor30 = tor30 | tm_reg[i][30];
        end
        sd = dor32 ? 2'd3 : (dor31 ? 2'd2 : (dor30 ? 2'd1 : 2'd0));
        st = tor31 ? 2'd2 : (tor30 ? 2'd1 : 2'd0);
        sl = dor32 ? 2'd2 : (dor31 ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < DIMENSION; i++)
            begin
                a_reg[i] <= 30'(dm_reg[i] >> sd);
                b_reg[i] <= 30'(tm_reg[i] >> st);
                f_reg[i] <= 31'(dm_reg[i] >> sl);
            end
            sgn_reg <= dneg_reg ^ tneg_reg;
            sl_reg  <= sl;
        end
    end

    // stage 3
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < DIMENSION; i++)
            begin
                pab_reg[i] <= 60'(a_reg[i]) * 60'(b_reg[i]);
                paa_reg[i] <= 60'(a_reg[i]) * 60'(a_reg[i]);
                pbb_reg[i] <= 60'(b_reg[i]) * 60'(b_reg[i]);
                pff_reg[i] <= 62'(f_reg[i]) * 62'(f_reg[i]);
            end
            sgn2_reg <= sgn_reg;
            sl2_reg  <= sl_reg;
        end
    end

    // stage 4
    always_comb
    begin
        for (int i = 0; i < DIMENSION; i++)
        begin
            term[i] = sgn2_reg[i] ? -$signed({3'b000, pab_reg[i]})
                                  : $signed({3'b000, pab_reg[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dot_reg <= term[0] + term[1] + term[2];
            ld2_reg <= 62'(paa_reg[0]) + 62'(paa_reg[1]) + 62'(paa_reg[2]);
            tl2_reg <= 62'(pbb_reg[0]) + 62'(pbb_reg[1]) + 62'(pbb_reg[2]);
            lf2_reg <= 64'(pff_reg[0]) + 64'(pff_reg[1]) + 64'(pff_reg[2]);
            sl3_reg <= sl2_reg;
        end
    end

    // first square root row
    assign sq1_rad[0][0]  = {2'b00, ld2_reg};
    assign sq1_rad[1][0]  = {2'b00, tl2_reg};
    assign sq1_rad[2][0]  = lf2_reg;
    assign q_abs          = dot_reg[62] ? 62'(-dot_reg) : 62'(dot_reg);

    for (genvar l = 0; l < 3; l++)
    begin : g_sq1_lane
        assign sq1_rem[l][0]  = '0;
        assign sq1_root[l][0] = '0;
        for (genvar k = 0; k < SQRT_CELLS; k++)
        begin : g_cell
            cre_sqrt_cell u_cell (
                .clk      (clk),
                .en       (adv),
                .rad_in   (sq1_rad[l][k]),
                .rem_in   (sq1_rem[l][k]),
                .root_in  (sq1_root[l][k]),
                .rad_out  (sq1_rad[l][k+1]),
                .rem_out  (sq1_rem[l][k+1]),
                .root_out (sq1_root[l][k+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq1_q_reg[0]  <= q_abs;
            sq1_sl_reg[0] <= sl3_reg;
            for (int k = 1; k < SQRT_CELLS; k++)
            begin
                sq1_q_reg[k]  <= sq1_q_reg[k-1];
                sq1_sl_reg[k] <= sq1_sl_reg[k-1];
            end
        end
    end

    // product of lengths and chord length
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg   <= 62'(sq1_root[0][SQRT_CELLS][30:0]) * 62'(sq1_root[1][SQRT_CELLS][30:0]);
            q_reg   <= sq1_q_reg[SQRT_CELLS-1];
            len_reg <= 34'(sq1_root[2][SQRT_CELLS]) << sq1_sl_reg[SQRT_CELLS-1];
        end
    end

    // cosine divider row
    assign dc_rem[0] = {2'b00, q_reg};
    assign dc_den[0] = {2'b00, p_reg};
    assign dc_quo[0] = '0;

    for (genvar k = 0; k < COS_CELLS; k++)
    begin : g_dc
        cre_div_cell #(
            .REM_W (64),
            .QUO_W (30)
        ) u_cell (
            .clk     (clk),
            .en      (adv),
            .rem_in  (dc_rem[k]),
            .den_in  (dc_den[k]),
            .nbit    (1'b0),
            .quo_in  (dc_quo[k]),
            .rem_out (dc_rem[k+1]),
            .den_out (dc_den[k+1]),
            .quo_out (dc_quo[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dc_big_reg[0] <= (q_reg >= p_reg);
            dc_pz_reg[0]  <= (p_reg == '0);
            dc_len_reg[0] <= len_reg;
            for (int k = 1; k < COS_CELLS; k++)
            begin
                dc_big_reg[k] <= dc_big_reg[k-1];
                dc_pz_reg[k]  <= dc_pz_reg[k-1];
                dc_len_reg[k] <= dc_len_reg[k-1];
            end
        end
    end

    // c clamp and square, then 1 - c^2
    always_comb
    begin
        if (dc_big_reg[COS_CELLS-1])
        begin
            csel = dc_pz_reg[COS_CELLS-1] ? 31'd0 : {1'b1, 30'd0};
        end
        else
        begin
            csel = {1'b0, dc_quo[COS_CELLS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cc_reg   <= 61'(csel) * 61'(csel);
            len4_reg <= dc_len_reg[COS_CELLS-1];
            v_reg    <= {1'b1, 60'd0} - cc_reg;
            len5_reg <= len4_reg;
        end
    end

    // second square root row
    assign sq2_rad[0]  = {3'b000, v_reg};
    assign sq2_rem[0]  = '0;
    assign sq2_root[0] = '0;

    for (genvar k = 0; k < SQRT_CELLS; k++)
    begin : g_sq2
        cre_sqrt_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .rad_in   (sq2_rad[k]),
            .rem_in   (sq2_rem[k]),
            .root_in  (sq2_root[k]),
            .rad_out  (sq2_rad[k+1]),
            .rem_out  (sq2_rem[k+1]),
            .root_out (sq2_root[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq2_len_reg[0] <= len5_reg;
            for (int k = 1; k < SQRT_CELLS; k++)
            begin
                sq2_len_reg[k] <= sq2_len_reg[k-1];
            end
        end
    end

    // radius divider row
    assign den   = {sq2_root[SQRT_CELLS][30:0], 1'b0};
    assign nofin = (den <= min_den_reg);
    assign ovf   = (sq2_len_reg[SQRT_CELLS-1][33:2] >= den);

    assign dr_rem[0]  = {1'b0, sq2_len_reg[SQRT_CELLS-1][33:2]};
    assign dr_den[0]  = {1'b0, den};
    assign dr_quo[0]  = '0;
    assign dr_nlow[0] = {sq2_len_reg[SQRT_CELLS-1][1:0], 30'd0};

    for (genvar k = 0; k < RAD_CELLS; k++)
    begin : g_dr
        cre_div_cell #(
            .REM_W (33),
            .QUO_W (32)
        ) u_cell (
            .clk     (clk),
            .en      (adv),
            .rem_in  (dr_rem[k]),
            .den_in  (dr_den[k]),
            .nbit    (dr_nlow[k][31]),
            .quo_in  (dr_quo[k]),
            .rem_out (dr_rem[k+1]),
            .den_out (dr_den[k+1]),
            .quo_out (dr_quo[k+1])
        );
        assign dr_nlow[k+1] = dr_nlow_reg[k];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dr_nofin_reg[0] <= nofin;
            dr_ovf_reg[0]   <= ovf;
            for (int k = 0; k < RAD_CELLS; k++)
            begin
                dr_nlow_reg[k] <= {dr_nlow[k][30:0], 1'b0};
            end
            for (int k = 1; k < RAD_CELLS; k++)
            begin
                dr_nofin_reg[k] <= dr_nofin_reg[k-1];
                dr_ovf_reg[k]   <= dr_ovf_reg[k-1];
            end
        end
    end

    // output word
    always_comb
    begin
        if (dr_nofin_reg[RAD_CELLS-1])
        begin
            result_next.radius = '0;
            result_next.status = STATUS_NO_RADIUS;
        end
        else if (dr_ovf_reg[RAD_CELLS-1])
        begin
            result_next.radius = '1;
            result_next.status = STATUS_SAT;
        end
        else
        begin
            result_next.radius = dr_quo[RAD_CELLS];
            result_next.status = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTH
    a_nofin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == STATUS_NO_RADIUS) |-> (result.radius == '0))
        else $error("no finite radius with nonzero radius");

    a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == STATUS_SAT) |-> (result.radius == '1))
        else $error("saturated radius not all ones");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while halted");

    a_accept_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && adv) |=> vld_reg[0])
        else $error("accepted word lost at pipeline entry");
`endif

endmodule

`default_nettype wire
